// ===== rtl/cosr_pkg.sv =====
// Package for the calibration overlay sector remap block.
// Sizes, operation and status codes, register indexes and the controller
// to datapath command and status types. No dependencies.
package cosr_pkg;

  // Geometry of the ROM reference page and the RAM work page
  localparam int SECTOR_LOG  = 10;
  localparam int ROM_SECTORS = 16;
  localparam int RAM_SECTORS = 8;

  // Table index and entry widths
  localparam int ROM_IDX_W = (ROM_SECTORS > 1) ? $clog2(ROM_SECTORS) : 1;
  localparam int RAM_IDX_W = (RAM_SECTORS > 1) ? $clog2(RAM_SECTORS) : 1;
  localparam int SEC_W     = $clog2(ROM_SECTORS + 1);
  localparam int SLOT_W    = $clog2(RAM_SECTORS + 2);

  // Size of the ROM page in bytes
  localparam logic [32:0] ROM_SPAN = 33'(ROM_SECTORS) << SECTOR_LOG;

  // Field widths
  localparam int ADDR_W     = 32;
  localparam int KIND_W     = 2;
  localparam int IN_SEC_W   = 8;
  localparam int STATUS_W   = 3;
  localparam int SEC_OUT_W  = 5;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_XLATE   = 2'd0,
    KIND_MAP     = 2'd1,
    KIND_UNMAP   = 2'd2,
    KIND_RELEASE = 2'd3
  } cosr_kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_BAD_SECTOR = 3'd1,
    ST_NOT_MAPPED = 3'd2,
    ST_RAM_FULL   = 3'd3,
    ST_NO_RELEASE = 3'd4
  } cosr_status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WORK_PAGE_EN = 2'd0,
    REG_ROM_BASE     = 2'd1,
    REG_RAM_BASE     = 2'd2
  } cosr_reg_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_STEP2,
    S_OUT
  } cosr_state_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic step2;
  } cosr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic two_step;
  } cosr_sts_t;

endpackage

// ===== rtl/cosr_ctrl.sv =====
// Sequencing controller for the overlay sector remap block.
// Depends on cosr_pkg for the state enum and the command/status structs.
module cosr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  cosr_pkg::cosr_sts_t sts_i,
  output cosr_pkg::cosr_cmd_t cmd_o
);

  cosr_pkg::cosr_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cosr_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      cosr_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = cosr_pkg::S_EXEC;
        end
      end
      cosr_pkg::S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.two_step ? cosr_pkg::S_STEP2 : cosr_pkg::S_OUT;
      end
      cosr_pkg::S_STEP2: begin
        cmd_o.step2 = 1'b1;
        state_d     = cosr_pkg::S_OUT;
      end
      cosr_pkg::S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = cosr_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = cosr_pkg::S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // Never accept an input while a result is on offer
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while result pending");

  // A captured item is always executed in the next cycle
  a_capture_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> cmd_o.exec)
    else $error("capture not followed by execute");

  // Execution is followed by step two or by the offered result
  a_exec_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> (out_valid_o || cmd_o.step2))
    else $error("execute not followed by step two or result");
`endif

endmodule

// ===== rtl/cosr_dp.sv =====
// Datapath for the overlay sector remap block: configuration registers,
// sector and slot tables, slot allocator and result registers.
// Depends on cosr_pkg for sizes, codes and the command/status structs.
module cosr_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  cosr_pkg::cosr_cmd_t                 cmd_i,
  output cosr_pkg::cosr_sts_t                 sts_o,
  input  logic                                cfg_write_i,
  input  logic [cosr_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [cosr_pkg::ADDR_W-1:0]         cfg_data_i,
  input  logic [cosr_pkg::KIND_W-1:0]         kind_i,
  input  logic [cosr_pkg::ADDR_W-1:0]         address_i,
  input  logic [cosr_pkg::IN_SEC_W-1:0]       rom_sector_i,
  output logic [cosr_pkg::STATUS_W-1:0]       status_o,
  output logic [cosr_pkg::ADDR_W-1:0]         address_out_o,
  output logic [cosr_pkg::SEC_OUT_W-1:0]      sector_out_o,
  output logic                                remapped_o
);

  localparam int SL = cosr_pkg::SECTOR_LOG;

  // Configuration
  logic                         wpe_q;
  logic [cosr_pkg::ADDR_W-1:0]  rom_base_q, ram_base_q;

  // Tables and allocator
  logic [cosr_pkg::SLOT_W-1:0]  rom_tbl_q [cosr_pkg::ROM_SECTORS];
  logic [cosr_pkg::SEC_W-1:0]   own_tbl_q [cosr_pkg::RAM_SECTORS];
  logic [cosr_pkg::SLOT_W-1:0]  nfs_q;

  // Captured item
  cosr_pkg::cosr_kind_e          kind_q;
  logic [cosr_pkg::ADDR_W-1:0]   addr_q;
  logic [cosr_pkg::IN_SEC_W-1:0] sec_q;

  // Intermediate values between execute and step two
  logic [cosr_pkg::ADDR_W-1:0]   off_q;
  logic [cosr_pkg::SEC_W-1:0]    rsec_q;
  logic [cosr_pkg::ROM_IDX_W-1:0] ridx_q;
  logic [cosr_pkg::SEC_W-1:0]    owner_q;
  logic                          rel_ok_q;

  // Result registers
  cosr_pkg::cosr_status_e          status_q;
  logic [cosr_pkg::ADDR_W-1:0]     aout_q;
  logic [cosr_pkg::SEC_OUT_W-1:0]  sout_q;
  logic                            remap_q;

  // Combinational helpers
  logic [cosr_pkg::ADDR_W-1:0]    off;
  logic                           in_page;
  logic                           bad_sec;
  logic [cosr_pkg::ROM_IDX_W-1:0] sidx;
  logic [cosr_pkg::RAM_IDX_W-1:0] nidx, nidx_m1;
  logic [cosr_pkg::SLOT_W-1:0]    sec_slot;
  logic [cosr_pkg::SLOT_W-1:0]    xl_slot, xl_slot_m1;
  logic [cosr_pkg::ROM_IDX_W-1:0] oidx;
  logic [cosr_pkg::SLOT_W-1:0]    own_slot;
  logic                           rel_go;
  logic [cosr_pkg::IN_SEC_W-1:0]  sec_m1;
  logic [cosr_pkg::SEC_W-1:0]     owner_m1;
  logic [cosr_pkg::SLOT_W-1:0]    nfs_m1, nfs_m2, sec_slot_m1, own_slot_m1;

  assign sts_o.two_step = (kind_q == cosr_pkg::KIND_XLATE) ||
                          (kind_q == cosr_pkg::KIND_RELEASE);

  // Address offset and page hit
  assign off     = addr_q - rom_base_q;
  assign in_page = (addr_q >= rom_base_q) && ({1'b0, off} < cosr_pkg::ROM_SPAN);

  // Sector and slot indexes
  assign bad_sec = (sec_q == '0) ||
                   (sec_q > cosr_pkg::IN_SEC_W'(cosr_pkg::ROM_SECTORS));
  assign sec_m1      = sec_q - 1'b1;
  assign sidx        = sec_m1[cosr_pkg::ROM_IDX_W-1:0];
  assign nfs_m1      = nfs_q - 1'b1;
  assign nfs_m2      = nfs_q - cosr_pkg::SLOT_W'(2);
  assign nidx        = nfs_m1[cosr_pkg::RAM_IDX_W-1:0];
  assign nidx_m1     = nfs_m2[cosr_pkg::RAM_IDX_W-1:0];
  assign sec_slot    = rom_tbl_q[sidx];
  assign sec_slot_m1 = sec_slot - 1'b1;

  // Translate lookup
  assign xl_slot    = rom_tbl_q[ridx_q];
  assign xl_slot_m1 = xl_slot - 1'b1;

  // Release lookup
  assign owner_m1    = owner_q - 1'b1;
  assign oidx        = owner_m1[cosr_pkg::ROM_IDX_W-1:0];
  assign own_slot    = rom_tbl_q[oidx];
  assign own_slot_m1 = own_slot - 1'b1;
  assign rel_go      = rel_ok_q && (owner_q != '0) &&
                       (owner_q <= cosr_pkg::SEC_W'(cosr_pkg::ROM_SECTORS)) &&
                       (own_slot != '0);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpe_q      <= 1'b0;
      rom_base_q <= '0;
      ram_base_q <= '0;
    end else if (cfg_write_i) begin
      case (cfg_index_i)
        cosr_pkg::REG_WORK_PAGE_EN: wpe_q      <= cfg_data_i[0];
        cosr_pkg::REG_ROM_BASE:     rom_base_q <= cfg_data_i;
        cosr_pkg::REG_RAM_BASE:     ram_base_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Item capture and intermediate values
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= cosr_pkg::cosr_kind_e'(kind_i);
      addr_q <= address_i;
      sec_q  <= rom_sector_i;
    end
    if (cmd_i.exec) begin
      off_q    <= off;
      rsec_q   <= in_page ? (cosr_pkg::SEC_W'(off[SL +: cosr_pkg::ROM_IDX_W]) + 1'b1)
                          : '0;
      ridx_q   <= off[SL +: cosr_pkg::ROM_IDX_W];
      owner_q  <= own_tbl_q[nidx_m1];
      rel_ok_q <= (nfs_q > cosr_pkg::SLOT_W'(1));
    end
  end

  // Tables, allocator and results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < cosr_pkg::ROM_SECTORS; i++) rom_tbl_q[i] <= '0;
      for (int i = 0; i < cosr_pkg::RAM_SECTORS; i++) own_tbl_q[i] <= '0;
      nfs_q    <= cosr_pkg::SLOT_W'(1);
      status_q <= cosr_pkg::ST_OK;
      aout_q   <= '0;
      sout_q   <= '0;
      remap_q  <= 1'b0;
    end else if (cmd_i.exec) begin
      status_q <= cosr_pkg::ST_OK;
      aout_q   <= '0;
      sout_q   <= '0;
      remap_q  <= 1'b0;
      case (kind_q)
        cosr_pkg::KIND_MAP: begin
          if (bad_sec) begin
            status_q <= cosr_pkg::ST_BAD_SECTOR;
          end else if (nfs_q > cosr_pkg::SLOT_W'(cosr_pkg::RAM_SECTORS)) begin
            status_q <= cosr_pkg::ST_RAM_FULL;
          end else begin
            rom_tbl_q[sidx] <= nfs_q;
            own_tbl_q[nidx] <= cosr_pkg::SEC_W'(sec_q);
            sout_q          <= cosr_pkg::SEC_OUT_W'(nfs_q);
            nfs_q           <= nfs_q + 1'b1;
          end
        end
        cosr_pkg::KIND_UNMAP: begin
          if (bad_sec) begin
            status_q <= cosr_pkg::ST_BAD_SECTOR;
          end else if (sec_slot == '0) begin
            status_q <= cosr_pkg::ST_NOT_MAPPED;
          end else begin
            own_tbl_q[sec_slot_m1[cosr_pkg::RAM_IDX_W-1:0]] <= '0;
            rom_tbl_q[sidx] <= '0;
          end
        end
        default: ;
      endcase
    end else if (cmd_i.step2) begin
      case (kind_q)
        cosr_pkg::KIND_XLATE: begin
          sout_q <= cosr_pkg::SEC_OUT_W'(rsec_q);
          if (wpe_q && (rsec_q != '0) && (xl_slot != '0)) begin
            aout_q  <= ram_base_q +
                       cosr_pkg::ADDR_W'({xl_slot_m1, off_q[SL-1:0]});
            remap_q <= 1'b1;
          end else begin
            aout_q <= addr_q;
          end
        end
        cosr_pkg::KIND_RELEASE: begin
          if (rel_go) begin
            own_tbl_q[own_slot_m1[cosr_pkg::RAM_IDX_W-1:0]] <= '0;
            rom_tbl_q[oidx] <= '0;
            nfs_q           <= nfs_m1;
            status_q        <= cosr_pkg::ST_OK;
          end else begin
            status_q <= cosr_pkg::ST_NO_RELEASE;
          end
        end
        default: ;
      endcase
    end
  end

  assign status_o      = status_q;
  assign address_out_o = aout_q;
  assign sector_out_o  = sout_q;
  assign remapped_o    = remap_q;

`ifndef SYNTHESIS
  // Allocator never leaves its legal range
  a_nfs_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nfs_q >= cosr_pkg::SLOT_W'(1)) &&
    (nfs_q <= cosr_pkg::SLOT_W'(cosr_pkg::RAM_SECTORS + 1)))
    else $error("next free slot out of range");

  // Tables and allocator only move in execute or step two
  a_nfs_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!cmd_i.exec && !cmd_i.step2) |=> $stable(nfs_q))
    else $error("allocator moved outside an operation");

  // Redirection always reports success
  a_remap_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    remap_q |-> (status_q == cosr_pkg::ST_OK))
    else $error("remapped result with error status");
`endif

endmodule

// ===== rtl/calibration_overlay_sector_remap.sv =====
// An item is accepted in the idle state. Map and unmap then pass through the
// execute state before the result is offered; translate and release also
// pass through step two for the second table lookup. One item at a time: no
// new item is accepted until the result has been taken.
// Reset (asynchronous, active low) clears the configuration, both tables,
// and sets the next free slot to 1; the block leaves reset in the idle state.
module calibration_overlay_sector_remap (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [cosr_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [cosr_pkg::ADDR_W-1:0]         cfg_data_i,
  // Input channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [cosr_pkg::KIND_W-1:0]         kind_i,
  input  logic [cosr_pkg::ADDR_W-1:0]         address_i,
  input  logic [cosr_pkg::IN_SEC_W-1:0]       rom_sector_i,
  // Output channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [cosr_pkg::STATUS_W-1:0]       status_o,
  output logic [cosr_pkg::ADDR_W-1:0]         address_out_o,
  output logic [cosr_pkg::SEC_OUT_W-1:0]      sector_out_o,
  output logic                                remapped_o
);

  cosr_pkg::cosr_cmd_t cmd;
  cosr_pkg::cosr_sts_t sts;

  // Configuration writes are always taken
  assign cfg_ready_o = 1'b1;

  cosr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cosr_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_write_i   (cfg_valid_i & cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .kind_i        (kind_i),
    .address_i     (address_i),
    .rom_sector_i  (rom_sector_i),
    .status_o      (status_o),
    .address_out_o (address_out_o),
    .sector_out_o  (sector_out_o),
    .remapped_o    (remapped_o)
  );

endmodule
